// ----- design/pcs_pkg.sv -----
`default_nettype none
package pcs_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int DEF_VALUE_BITS   = 32;

    // width of one color channel
    localparam int COLOR_W = 8;

    // request kinds on the input tuser
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // status codes on the output tuser
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W  = 2;
    localparam logic [1:0] CFG_SMOOTH = 2'd0;
    localparam logic [1:0] CFG_ALPHA  = 2'd1;

    localparam logic         SMOOTH_RESET = 1'b1;
    localparam logic [7:0]   ALPHA_RESET  = 8'd255;

endpackage
`default_nettype wire

// ----- design/pcs_seg_mem.sv -----
`default_nettype none
module pcs_seg_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 112,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- design/pcs_blend.sv -----
`default_nettype none
// One channel of round-half-up interpolation:
// q = floor((2*(ca*(d-t) + cb*t) + d) / (2*d)), one multiplier, restoring divider.
module pcs_blend #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pcs_pkg::COLOR_W-1:0] i_ca,
    input  wire logic [pcs_pkg::COLOR_W-1:0] i_cb,
    input  wire logic [VALUE_BITS-1:0]       i_d,
    input  wire logic [VALUE_BITS-1:0]       i_t,
    input  wire logic [VALUE_BITS-1:0]       i_dmt,
    output logic                             o_done,
    output logic [pcs_pkg::COLOR_W-1:0]      o_q
);

    localparam int CW    = pcs_pkg::COLOR_W;
    localparam int ACC_W = VALUE_BITS + CW;
    localparam int REM_W = VALUE_BITS + CW + 1;
    localparam int CNT_W = $clog2(CW);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL0 = 5'b00010,
        B_MUL1 = 5'b00100,
        B_NUM  = 5'b01000,
        B_DIV  = 5'b10000
    } t_bstate;

    t_bstate            r_state;
    t_bstate            n_state;
    logic [ACC_W-1:0]   r_acc;
    logic [REM_W-1:0]   r_rem;
    logic [ACC_W-1:0]   r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic [CW-1:0]      r_q;
    logic               r_done;

    logic [CW-1:0]         mul_a;
    logic [VALUE_BITS-1:0] mul_b;
    logic [ACC_W-1:0]      mul_p;
    logic                  div_ge;

    assign mul_a  = (r_state == B_MUL0) ? i_ca : i_cb;
    assign mul_b  = (r_state == B_MUL0) ? i_dmt : i_t;
    assign mul_p  = ACC_W'(mul_a) * ACC_W'(mul_b);
    assign div_ge = (r_rem >= {1'b0, r_den});

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (i_start) n_state = B_MUL0;
            B_MUL0: n_state = B_MUL1;
            B_MUL1: n_state = B_NUM;
            B_NUM:  n_state = B_DIV;
            B_DIV:  if (r_cnt == '0) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == B_DIV) && (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_MUL0: r_acc <= mul_p;
            B_MUL1: r_acc <= r_acc + mul_p;
            B_NUM: begin
                r_rem <= {r_acc, 1'b0} + REM_W'(i_d);
                r_den <= {i_d, {CW{1'b0}}};
                r_cnt <= CNT_W'(CW - 1);
                r_q   <= '0;
            end
            B_DIV: begin
                // one quotient bit per cycle, most significant first
                if (div_ge) begin
                    r_rem <= r_rem - {1'b0, r_den};
                end
                r_q   <= {r_q[CW-2:0], div_ge};
                r_den <= r_den >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule
`default_nettype wire

// ----- design/piecewise_color_scale_lookup.sv -----
`default_nettype none
// Piecewise color scale lookup.
// Input stream s_axis: tuser carries the request kind (clear, append, look up);
// tdata carries sample, segment bounds and the two end colors. Output stream
// m_axis: tuser carries the status, tdata the color and alpha. One result per item.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write smooth mode (index 0) and
// alpha (index 1); write only while no item is in flight.
// One item at a time: s_axis_tready is high only while the block is idle.
// Clear, append and unused kinds, and lookups on an empty table, go straight to
// the done state. Lookup: each binary search step takes a read state and a
// compare state (one segment memory read each); then the segment is fetched and
// classified. Smooth mode inside a segment runs each channel in turn through the
// single multiply/divide unit; stepped mode or clamped values finish without it.
// Reset empties the table and sets smooth mode and alpha 255; table contents
// are not cleared. A stalled receiver holds the result in the output register;
// the next item is taken meanwhile, and its result waits until that one leaves.
module piecewise_color_scale_lookup #(
    parameter int MAX_SEGMENTS = pcs_pkg::DEF_MAX_SEGMENTS,
    parameter int VALUE_BITS   = pcs_pkg::DEF_VALUE_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_value, seg_low_bound, seg_high_bound, low_red, low_green, low_blue,
    // high_red, high_green, high_blue, zero pad
    input  wire logic [((3*VALUE_BITS+6*pcs_pkg::COLOR_W+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  wire logic [1:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [4*pcs_pkg::COLOR_W-1:0]       m_axis_tdata,
    // status
    output logic [1:0]                          m_axis_tuser,
    input  wire logic                           i_cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pcs_pkg::COLOR_W-1:0]    i_cfg_data
);

    localparam int VB   = VALUE_BITS;
    localparam int CLW  = pcs_pkg::COLOR_W;
    localparam int RGBW = 3 * CLW;
    localparam int IW   = $clog2(MAX_SEGMENTS);
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int MW   = 2 * VB + 2 * RGBW;
    localparam int OFS_CA = 3 * VB;
    localparam int OFS_CB = 3 * VB + RGBW;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b00000001,
        S_SRCH_RD  = 8'b00000010,
        S_SRCH_CMP = 8'b00000100,
        S_SEG_EVAL = 8'b00001000,
        S_PICK     = 8'b00010000,
        S_BLEND    = 8'b00100000,
        S_BWAIT    = 8'b01000000,
        S_DONE     = 8'b10000000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_smooth;
    logic [CLW-1:0]   r_alpha;
    logic [CNTW-1:0]  r_count;
    logic [VB-1:0]    r_last_high;
    logic [VB-1:0]    r_v;
    logic [IW-1:0]    r_lo_i;
    logic [IW-1:0]    r_hi_i;
    logic [IW-1:0]    r_mid;
    logic             r_le_lo;
    logic             r_ge_hi;
    logic [VB-1:0]    r_d;
    logic [VB-1:0]    r_t;
    logic [VB-1:0]    r_dmt;
    logic [RGBW-1:0]  r_ca;
    logic [RGBW-1:0]  r_cb;
    logic [1:0]       r_ch;
    logic [1:0]       r_res_status;
    logic [RGBW-1:0]  r_res_rgb;
    logic [CLW-1:0]   r_res_a;
    logic             r_mvalid;
    logic [1:0]       r_mstatus;
    logic [4*CLW-1:0] r_mdata;

    logic             in_acc;
    logic [VB-1:0]    in_v;
    logic [VB-1:0]    in_lo;
    logic [VB-1:0]    in_hi;
    logic [RGBW-1:0]  in_ca;
    logic [RGBW-1:0]  in_cb;
    logic             app_refused;
    logic             mem_we;
    logic [IW-1:0]    mem_raddr;
    logic [MW-1:0]    mem_rdata;
    logic [VB-1:0]    rd_lo;
    logic [VB-1:0]    rd_hi;
    logic [IW:0]      mid_sum;
    logic [IW-1:0]    srch_mid;
    logic             srch_more;
    logic             slot_free;
    logic             blend_start;
    logic             blend_done;
    logic [CLW-1:0]   blend_q;
    logic [CLW-1:0]   ch_ca;
    logic [CLW-1:0]   ch_cb;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign in_v  = s_axis_tdata[VB-1:0];
    assign in_lo = s_axis_tdata[2*VB-1:VB];
    assign in_hi = s_axis_tdata[3*VB-1:2*VB];
    // table colors are packed red high, blue low
    assign in_ca = {s_axis_tdata[OFS_CA+CLW-1:OFS_CA],
                    s_axis_tdata[OFS_CA+2*CLW-1:OFS_CA+CLW],
                    s_axis_tdata[OFS_CA+3*CLW-1:OFS_CA+2*CLW]};
    assign in_cb = {s_axis_tdata[OFS_CB+CLW-1:OFS_CB],
                    s_axis_tdata[OFS_CB+2*CLW-1:OFS_CB+CLW],
                    s_axis_tdata[OFS_CB+3*CLW-1:OFS_CB+2*CLW]};

    assign app_refused = (r_count >= CNTW'(MAX_SEGMENTS))
                      || ($signed(in_lo) >= $signed(in_hi))
                      || ((r_count != '0) && (in_lo != r_last_high));
    assign mem_we = in_acc && (s_axis_tuser == pcs_pkg::REQ_APPEND) && !app_refused;

    assign mid_sum   = (IW+1)'(r_lo_i) + (IW+1)'(r_hi_i) + (IW+1)'(1);
    assign srch_mid  = mid_sum[IW:1];
    assign srch_more = (r_lo_i < r_hi_i);
    assign mem_raddr = srch_more ? srch_mid : r_lo_i;

    assign rd_lo = mem_rdata[VB-1:0];
    assign rd_hi = mem_rdata[2*VB-1:VB];

    assign slot_free = !r_mvalid || m_axis_tready;

    pcs_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (MW),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({in_cb, in_ca, in_hi, in_lo}),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        case (r_ch)
            CH_RED:   begin ch_ca = r_ca[3*CLW-1:2*CLW]; ch_cb = r_cb[3*CLW-1:2*CLW]; end
            CH_GREEN: begin ch_ca = r_ca[2*CLW-1:CLW];   ch_cb = r_cb[2*CLW-1:CLW];   end
            default:  begin ch_ca = r_ca[CLW-1:0];       ch_cb = r_cb[CLW-1:0];       end
        endcase
    end

    assign blend_start = (r_state == S_BLEND);

    pcs_blend #(
        .VALUE_BITS (VB)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (blend_start),
        .i_ca    (ch_ca),
        .i_cb    (ch_cb),
        .i_d     (r_d),
        .i_t     (r_t),
        .i_dmt   (r_dmt),
        .o_done  (blend_done),
        .o_q     (blend_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == pcs_pkg::REQ_LOOKUP && r_count != '0) begin
                        n_state = S_SRCH_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SRCH_RD:  n_state = srch_more ? S_SRCH_CMP : S_SEG_EVAL;
            S_SRCH_CMP: n_state = S_SRCH_RD;
            S_SEG_EVAL: n_state = S_PICK;
            S_PICK: begin
                if (r_le_lo || r_ge_hi || !r_smooth) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: n_state = S_BWAIT;
            S_BWAIT: begin
                if (blend_done) begin
                    n_state = (r_ch == CH_BLUE) ? S_DONE : S_BLEND;
                end
            end
            S_DONE: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_smooth <= pcs_pkg::SMOOTH_RESET;
            r_alpha  <= pcs_pkg::ALPHA_RESET;
            r_count  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcs_pkg::CFG_SMOOTH: r_smooth <= i_cfg_data[0];
                    pcs_pkg::CFG_ALPHA:  r_alpha  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && s_axis_tuser == pcs_pkg::REQ_CLEAR) begin
                r_count <= '0;
            end else if (mem_we) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_DONE && slot_free) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_res_rgb    <= '0;
                r_res_a      <= '0;
                r_res_status <= pcs_pkg::ST_OK;
                r_v          <= in_v;
                r_lo_i       <= '0;
                r_hi_i       <= IW'(r_count - 1'b1);
                if (mem_we) begin
                    r_last_high <= in_hi;
                end
                case (s_axis_tuser)
                    pcs_pkg::REQ_APPEND: begin
                        if (app_refused) r_res_status <= pcs_pkg::ST_REFUSED;
                    end
                    pcs_pkg::REQ_LOOKUP: begin
                        if (r_count == '0) begin
                            r_res_status <= pcs_pkg::ST_EMPTY;
                        end else begin
                            r_res_a <= r_alpha;
                        end
                    end
                    default: ;
                endcase
            end
            S_SRCH_RD: begin
                r_mid <= srch_mid;
            end
            S_SRCH_CMP: begin
                // keep the largest index whose low bound is at or below the value
                if ($signed(rd_lo) <= $signed(r_v)) begin
                    r_lo_i <= r_mid;
                end else begin
                    r_hi_i <= r_mid - 1'b1;
                end
            end
            S_SEG_EVAL: begin
                r_le_lo <= ($signed(r_v) <= $signed(rd_lo));
                r_ge_hi <= ($signed(r_v) >= $signed(rd_hi));
                r_d     <= rd_hi - rd_lo;
                r_t     <= r_v - rd_lo;
                r_dmt   <= rd_hi - r_v;
                r_ca    <= mem_rdata[2*VB+RGBW-1:2*VB];
                r_cb    <= mem_rdata[MW-1:2*VB+RGBW];
            end
            S_PICK: begin
                r_ch <= CH_RED;
                if (r_le_lo) begin
                    r_res_rgb <= r_ca;
                end else if (r_ge_hi) begin
                    r_res_rgb <= r_cb;
                end else if (!r_smooth) begin
                    r_res_rgb <= (r_t > r_dmt) ? r_cb : r_ca;
                end
            end
            S_BWAIT: begin
                if (blend_done) begin
                    case (r_ch)
                        CH_RED:   r_res_rgb[3*CLW-1:2*CLW] <= blend_q;
                        CH_GREEN: r_res_rgb[2*CLW-1:CLW]   <= blend_q;
                        default:  r_res_rgb[CLW-1:0]       <= blend_q;
                    endcase
                    r_ch <= r_ch + 1'b1;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    r_mstatus <= r_res_status;
                    r_mdata   <= {r_res_a, r_res_rgb[CLW-1:0],
                                  r_res_rgb[2*CLW-1:CLW], r_res_rgb[3*CLW-1:2*CLW]};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_mstatus;

endmodule
`default_nettype wire

// ----- verif/color_scale_checker.sv -----
module color_scale_checker #(
    parameter int SEGMENTS = pcs_pkg::DEF_MAX_SEGMENTS,
    parameter int IN_W     = 144
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    // sample_value, seg_low_bound, seg_high_bound, low_red, low_green, low_blue,
    // high_red, high_green, high_blue
    input  wire logic [IN_W-1:0]                  s_axis_tdata,
    // req_type
    input  wire logic [1:0]                       s_axis_tuser,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    input  wire logic [4*pcs_pkg::COLOR_W-1:0]    m_axis_tdata,
    // status
    input  wire logic [1:0]                       m_axis_tuser,
    input  wire logic                             i_cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pcs_pkg::COLOR_W-1:0]      i_cfg_data,
    output int                                    o_errors,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_color_result;

    logic signed [31:0] seg_low  [SEGMENTS];
    logic signed [31:0] seg_high [SEGMENTS];
    logic [23:0]        col_low  [SEGMENTS];
    logic [23:0]        col_high [SEGMENTS];
    int unsigned        seg_count = 0;
    logic               smooth = pcs_pkg::SMOOTH_RESET;
    logic [7:0]         alpha = pcs_pkg::ALPHA_RESET;

    t_color_result expected_colors[$];
    int            mismatch_count = 0;
    int            pending_count = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = pending_count;

    // round half up: floor((2*(ca*(d-t) + cb*t) + d) / (2*d))
    function automatic logic [7:0] blend_channel(logic [7:0] ca, logic [7:0] cb,
                                                 longint unsigned d, longint unsigned t);
        longint unsigned a;
        longint unsigned b;
        longint unsigned num;
        a = ca;
        b = cb;
        num = 2 * (a * (d - t) + b * t) + d;
        return 8'(num / (2 * d));
    endfunction

    function automatic logic [23:0] segment_color(int unsigned idx, logic signed [31:0] v);
        longint d;
        longint t;
        if (v <= seg_low[idx])
            return col_low[idx];
        if (v >= seg_high[idx])
            return col_high[idx];
        d = longint'(seg_high[idx]) - longint'(seg_low[idx]);
        t = longint'(v) - longint'(seg_low[idx]);
        if (!smooth)
            return (t > d - t) ? col_high[idx] : col_low[idx];
        return {blend_channel(col_low[idx][23:16], col_high[idx][23:16], d, t),
                blend_channel(col_low[idx][15:8],  col_high[idx][15:8],  d, t),
                blend_channel(col_low[idx][7:0],   col_high[idx][7:0],   d, t)};
    endfunction

    // update the table copy and return the color the block owes for this item
    function automatic t_color_result predict_color(logic [1:0] kind, logic [IN_W-1:0] req);
        t_color_result      res;
        logic signed [31:0] sample;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        int unsigned        first;
        int unsigned        last;
        int unsigned        mid;
        logic [23:0]        c;
        res = '0;
        sample = req[31:0];
        lo = req[63:32];
        hi = req[95:64];
        case (kind)
            pcs_pkg::REQ_CLEAR: begin
                seg_count = 0;
            end
            pcs_pkg::REQ_APPEND: begin
                if (seg_count >= SEGMENTS || lo >= hi ||
                    (seg_count > 0 && lo != seg_high[seg_count - 1])) begin
                    res.status = pcs_pkg::ST_REFUSED;
                end else begin
                    seg_low[seg_count]  = lo;
                    seg_high[seg_count] = hi;
                    col_low[seg_count]  = {req[103:96], req[111:104], req[119:112]};
                    col_high[seg_count] = {req[127:120], req[135:128], req[143:136]};
                    seg_count++;
                end
            end
            pcs_pkg::REQ_LOOKUP: begin
                if (seg_count == 0) begin
                    res.status = pcs_pkg::ST_EMPTY;
                end else begin
                    // last segment whose low bound is at or below the sample
                    first = 0;
                    last = seg_count - 1;
                    while (first < last) begin
                        mid = (first + last + 1) / 2;
                        if (seg_low[mid] <= sample)
                            first = mid;
                        else
                            last = mid - 1;
                    end
                    c = segment_color(first, sample);
                    res.red   = c[23:16];
                    res.green = c[15:8];
                    res.blue  = c[7:0];
                    res.alpha = alpha;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_color_result want;
        if (!i_rst_n) begin
            seg_count = 0;
            smooth = pcs_pkg::SMOOTH_RESET;
            alpha = pcs_pkg::ALPHA_RESET;
            expected_colors.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_colors.size() == 0) begin
                    $error("unexpected result: status %0d data %h", m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_colors.pop_front();
                    check_field("status", int'(want.status), int'(m_axis_tuser));
                    check_field("out_red", int'(want.red), int'(m_axis_tdata[7:0]));
                    check_field("out_green", int'(want.green), int'(m_axis_tdata[15:8]));
                    check_field("out_blue", int'(want.blue), int'(m_axis_tdata[23:16]));
                    check_field("out_alpha", int'(want.alpha), int'(m_axis_tdata[31:24]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_colors.insert(expected_colors.size(),
                                       predict_color(s_axis_tuser, s_axis_tdata));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcs_pkg::CFG_SMOOTH: smooth = i_cfg_data[0];
                    pcs_pkg::CFG_ALPHA:  alpha = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending_count = expected_colors.size();
    end

endmodule

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W     = pcs_pkg::DEF_VALUE_BITS;
    localparam int MAX_SEGS    = pcs_pkg::DEF_MAX_SEGMENTS;
    localparam int IN_W        = ((3 * VALUE_W + 6 * pcs_pkg::COLOR_W + 7) / 8) * 8;
    localparam int VAL_MIN     = 32'sh8000_0000;
    localparam int VAL_MAX     = 32'sh7fff_ffff;
    localparam int TOTAL_ITEMS = 1050;
    localparam int PHASE_ITEMS = 175;
    localparam int CALM_ITEMS  = 150;
    localparam int IDLE_LIMIT  = 5000;

    // request kind the block ignores, register slots with nothing behind them
    localparam logic [1:0]                    REQ_UNUSED   = 2'd3;
    localparam logic [pcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [pcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [IN_W-1:0]               s_axis_tdata = '0;
    logic [1:0]                    s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [4*pcs_pkg::COLOR_W-1:0] m_axis_tdata;
    logic [1:0]                    m_axis_tuser;
    logic                          i_cfg_we = 1'b0;
    logic [pcs_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [pcs_pkg::COLOR_W-1:0]   i_cfg_data = '0;

    int mismatches;
    int pending;
    int sent_items = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    bit tx_gappy = 1'b1;
    bit rx_gappy = 1'b1;
    int scale_cuts[$];

    piecewise_color_scale_lookup u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    color_scale_checker #(
        .SEGMENTS (MAX_SEGS),
        .IN_W     (IN_W)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (mismatches),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    // receiver: stall bursts, with quiet stretches and none near the end
    always @(posedge i_clk) begin
        if ($urandom_range(0, 255) == 0)
            rx_gappy = !rx_gappy;
        if (!calm && rx_gappy && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 14);
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [IN_W-1:0] pack_request(int sample, int lo, int hi,
                                                     logic [23:0] c_low, logic [23:0] c_high);
        return {c_high[7:0], c_high[15:8], c_high[23:16],
                c_low[7:0], c_low[15:8], c_low[23:16], hi, lo, sample};
    endfunction

    function automatic logic [23:0] random_color();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // leaves tvalid high so back-to-back items need no extra edge
    task automatic send_item(logic [1:0] kind, logic [IN_W-1:0] payload);
        if (!calm && tx_gappy && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        if ($urandom_range(0, 63) == 0)
            tx_gappy = !tx_gappy;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= payload;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind != REQ_UNUSED)
            sent_items++;
    endtask

    task automatic look_up(int v);
        send_item(pcs_pkg::REQ_LOOKUP, pack_request(v, int'($urandom), int'($urandom),
                                                    random_color(), random_color()));
    endtask

    task automatic append_segment(int lo, int hi, logic [23:0] c_low, logic [23:0] c_high);
        send_item(pcs_pkg::REQ_APPEND, pack_request(int'($urandom), lo, hi, c_low, c_high));
    endtask

    task automatic clear_scale();
        send_item(pcs_pkg::REQ_CLEAR,
                  pack_request(int'($urandom), int'($urandom), int'($urandom),
                               random_color(), random_color()));
    endtask

    // an append the block must turn down; tail is the current last high bound
    task automatic send_refused_append(bit have_tail, int tail);
        int lo;
        int hi;
        int tmp;
        case ($urandom_range(0, have_tail ? 2 : 1))
            0: begin
                lo = int'($urandom);
                hi = lo;
            end
            1: begin
                lo = int'($urandom);
                hi = int'($urandom);
                if (lo < hi) begin
                    tmp = lo;
                    lo = hi;
                    hi = tmp;
                end
            end
            default: begin
                lo = tail ^ (32'sd1 << $urandom_range(0, 31));
                hi = VAL_MAX;
            end
        endcase
        append_segment(lo, hi, random_color(), random_color());
    endtask

    // hold the inputs quiet until every result is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic configure(logic smooth_on, logic [7:0] alpha);
        logic [7:0] junk;
        junk = 8'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pcs_pkg::CFG_SMOOTH;
        i_cfg_data <= {junk[7:1], smooth_on};
        @(posedge i_clk);
        i_cfg_idx  <= pcs_pkg::CFG_ALPHA;
        i_cfg_data <= alpha;
        @(posedge i_clk);
        i_cfg_idx  <= junk[0] ? CFG_SPARE_LO : CFG_SPARE_HI;
        i_cfg_data <= junk;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic build_scale(int segs, bit spread);
        int     cuts[$];
        longint next;
        bit     distinct;
        if (spread) begin
            // cut points drawn over the whole value range
            do begin
                cuts.delete();
                repeat (segs + 1) cuts.insert(cuts.size(), int'($urandom));
                cuts.sort();
                distinct = 1'b1;
                for (int k = 1; k < cuts.size(); k++)
                    if (cuts[k] == cuts[k - 1])
                        distinct = 1'b0;
            end while (!distinct);
        end else begin
            case ($urandom_range(0, 3))
                0: cuts.insert(cuts.size(), VAL_MIN);
                1: cuts.insert(cuts.size(), VAL_MAX - int'($urandom_range(1, 32'd1 << 26)));
                default: cuts.insert(cuts.size(),
                                     int'($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000);
            endcase
            repeat (segs) begin
                next = longint'(cuts[cuts.size() - 1]) +
                       longint'($urandom_range(1, 32'd1 << $urandom_range(0, 24)));
                if (next <= longint'(VAL_MAX))
                    cuts.insert(cuts.size(), int'(next));
            end
            if (cuts.size() < 2)
                cuts.insert(cuts.size(), VAL_MAX);
        end
        for (int k = 0; k + 1 < cuts.size(); k++) begin
            if ($urandom_range(0, 9) == 0)
                send_refused_append(k > 0, cuts[k]);
            append_segment(cuts[k], cuts[k + 1], random_color(), random_color());
        end
        scale_cuts = cuts;
    endtask

    task automatic run_episode(bit force_full);
        int              segs;
        int              idx;
        int              v;
        longint          span;
        longint unsigned pick;
        if (force_full || scale_cuts.size() == 0 || $urandom_range(0, 7) != 0) begin
            clear_scale();
            scale_cuts.delete();
            if ($urandom_range(0, 3) == 0)
                look_up(int'($urandom));
            if ($urandom_range(0, 7) == 0)
                send_refused_append(1'b0, 0);
            segs = (force_full || $urandom_range(0, 2) == 0) ? MAX_SEGS
                                                             : $urandom_range(1, MAX_SEGS - 1);
            build_scale(segs, force_full || $urandom_range(0, 1) == 1);
        end
        // table full: one more contiguous append gets refused
        if (scale_cuts.size() == MAX_SEGS + 1 && (force_full || $urandom_range(0, 1) == 0))
            append_segment(scale_cuts[scale_cuts.size() - 1], VAL_MAX,
                           random_color(), random_color());
        repeat ($urandom_range(2, 10)) begin
            idx = $urandom_range(0, scale_cuts.size() - 1);
            case ($urandom_range(0, 7))
                0: v = int'($urandom);
                1: v = scale_cuts[idx];
                2: v = scale_cuts[idx] - 1;
                3: v = scale_cuts[idx] + 1;
                4, 5: begin
                    // segment middle: exact tie when the width is even
                    if (idx == scale_cuts.size() - 1)
                        idx--;
                    v = int'(longint'(scale_cuts[idx]) +
                             (longint'(scale_cuts[idx + 1]) - longint'(scale_cuts[idx])) / 2);
                end
                default: begin
                    span = longint'(scale_cuts[scale_cuts.size() - 1]) - longint'(scale_cuts[0]);
                    pick = {$urandom, $urandom};
                    v = int'(longint'(scale_cuts[0]) + longint'(pick % (span + 1)));
                end
            endcase
            look_up(v);
        end
        if ($urandom_range(0, 15) == 0)
            send_item(REQ_UNUSED, pack_request(int'($urandom), int'($urandom), int'($urandom),
                                               random_color(), random_color()));
    endtask

    initial begin
        int phase;
        int next_phase_at;
        bit first;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, smooth with full alpha
        look_up(0);
        append_segment(0, 0, 24'h123456, 24'h654321);
        append_segment(100, -100, 24'h000000, 24'hffffff);
        append_segment(VAL_MIN, -65536, 24'h000000, 24'hffffff);
        append_segment(0, 65536, 24'hffffff, 24'hffffff);
        append_segment(-65536, 65536, 24'hff0080, 24'h00ff01);
        append_segment(65536, VAL_MAX, 24'hffffff, 24'h000000);
        look_up(VAL_MIN);
        look_up(VAL_MIN + 1);
        look_up(-65536);
        look_up(0);
        look_up(1);
        look_up(65536);
        look_up(VAL_MAX - 1);
        look_up(VAL_MAX);
        send_item(REQ_UNUSED, pack_request(VAL_MAX, VAL_MIN, VAL_MAX, 24'hffffff, 24'hffffff));
        clear_scale();
        look_up(VAL_MAX);

        phase = 0;
        next_phase_at = sent_items;
        first = 1'b1;
        while (sent_items < TOTAL_ITEMS) begin
            if (sent_items >= next_phase_at) begin
                settle();
                case (phase)
                    0: configure(1'b0, 8'd0);
                    1: configure(1'b1, 8'($urandom));
                    2: configure(1'b0, 8'd255);
                    3: configure(1'b1, 8'd0);
                    default: configure(1'($urandom), 8'($urandom));
                endcase
                phase++;
                next_phase_at += PHASE_ITEMS;
            end
            if (sent_items >= TOTAL_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            run_episode(first);
            first = 1'b0;
        end

        settle();
        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
